FILE: hdl/fgn_pkg.sv
// Shared types, constants and the permutation table of the fractal gradient noise block.
`timescale 1ns / 1ps
package fgn_pkg;

  // Default values for the top-level parameters.
  localparam int MAX_OCTAVES_DEF     = 8;
  localparam int COORD_FRAC_BITS_DEF = 12;

  // Fixed field widths.
  localparam int COORD_W = 24;
  localparam int CFG_W   = 16;
  localparam int CNT_W   = 4;
  localparam int IDX_W   = 2;
  localparam int OUT_W   = 16;
  localparam int FREQ_W  = 48;
  localparam int AMP_W   = 17;
  localparam int LEFT_W  = 5;

  // Accumulator widths, sized for up to 16 octaves.
  localparam int TOT_W  = 44;
  localparam int WSUM_W = 21;

  // Divider widths.
  localparam int DIV_D_W = WSUM_W + 1;
  localparam int REM_W   = DIV_D_W + 16;
  localparam int NUM_W   = TOT_W + 1;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] CFG_IDX_OCTAVES     = 2'd0;
  localparam logic [IDX_W-1:0] CFG_IDX_PERSISTENCE = 2'd1;
  localparam logic [IDX_W-1:0] CFG_IDX_LACUNARITY  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [CNT_W-1:0] OCTAVES_RST     = 4'd4;
  localparam logic [CFG_W-1:0] PERSISTENCE_RST = 16'd32768;
  localparam logic [CFG_W-1:0] LACUNARITY_RST  = 16'd8192;

  // Unity in the frequency and amplitude formats.
  localparam logic [FREQ_W-1:0] FREQ_ONE = 48'h0000_0001_0000;
  localparam logic [AMP_W-1:0]  AMP_ONE  = 17'h10000;

  // One sample travelling down the octave chain.
  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [FREQ_W-1:0]         freq;
    logic [AMP_W-1:0]          amp;
    logic signed [TOT_W-1:0]   total;
    logic [WSUM_W-1:0]         wsum;
    logic [LEFT_W-1:0]         left;
  } item_t;

  localparam logic [7:0] PERM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

endpackage

FILE: hdl/fractal_gradient_noise_2d.sv
// Top level of the fractal 2-D gradient noise generator.
`timescale 1ns / 1ps
// Channel   Ports                                   Transaction when
// -------   -------------------------------------   ---------------------------
// input     start, busy, in_coord_x, in_coord_y     start high, busy low
// result    out_valid, out_noise_value              out_valid high (one cycle)
// config    cfg_we, cfg_index, cfg_wdata            cfg_we high
//
// A new point is taken on every clock; busy is always low. Each result leaves
// through one input register, nine stages in each octave cell of the chain and
// nineteen in the output divider, which resolves one quotient bit per restoring
// step. Results come out in input order, one per transaction, and the receiver
// cannot stall them. Reset (rst_n, synchronous) clears the valid bits and loads
// the configuration defaults.
module fractal_gradient_noise_2d #(
  parameter int MAX_OCTAVES     = fgn_pkg::MAX_OCTAVES_DEF,
  parameter int COORD_FRAC_BITS = fgn_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [fgn_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [fgn_pkg::COORD_W-1:0] in_coord_y,
  output logic                               out_valid,
  output logic [fgn_pkg::OUT_W-1:0]          out_noise_value,
  input  logic                               cfg_we,
  input  logic [fgn_pkg::IDX_W-1:0]          cfg_index,
  input  logic [fgn_pkg::CFG_W-1:0]          cfg_wdata
);

  // Configuration registers.
  logic [fgn_pkg::CNT_W-1:0] octave_count_r;
  logic [fgn_pkg::CFG_W-1:0] persistence_r;
  logic [fgn_pkg::CFG_W-1:0] lacunarity_r;

  // Input register feeding the head of the chain.
  logic                       in_vld_r;
  fgn_pkg::item_t             in_item_r;
  fgn_pkg::item_t             in_item_nxt;
  logic [fgn_pkg::LEFT_W-1:0] octaves_eff;

  logic           chain_vld  [0:MAX_OCTAVES];
  fgn_pkg::item_t chain_item [0:MAX_OCTAVES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_count_r <= fgn_pkg::OCTAVES_RST;
      persistence_r  <= fgn_pkg::PERSISTENCE_RST;
      lacunarity_r   <= fgn_pkg::LACUNARITY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fgn_pkg::CFG_IDX_OCTAVES: begin
          octave_count_r <= cfg_wdata[fgn_pkg::CNT_W-1:0];
        end
        fgn_pkg::CFG_IDX_PERSISTENCE: begin
          persistence_r <= cfg_wdata;
        end
        fgn_pkg::CFG_IDX_LACUNARITY: begin
          lacunarity_r <= cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  // A zero count still runs one octave; counts above the chain length are clipped.
  always_comb begin
    if (octave_count_r == '0) begin
      octaves_eff = fgn_pkg::LEFT_W'(1);
    end else if (fgn_pkg::LEFT_W'(octave_count_r) > fgn_pkg::LEFT_W'(MAX_OCTAVES)) begin
      octaves_eff = fgn_pkg::LEFT_W'(MAX_OCTAVES);
    end else begin
      octaves_eff = fgn_pkg::LEFT_W'(octave_count_r);
    end
    in_item_nxt.cx    = in_coord_x;
    in_item_nxt.cy    = in_coord_y;
    in_item_nxt.freq  = fgn_pkg::FREQ_ONE;
    in_item_nxt.amp   = fgn_pkg::AMP_ONE;
    in_item_nxt.total = '0;
    in_item_nxt.wsum  = '0;
    in_item_nxt.left  = octaves_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_item_r <= in_item_nxt;
  end

  assign busy          = 1'b0;
  assign chain_vld[0]  = in_vld_r;
  assign chain_item[0] = in_item_r;

  // Each cell evaluates one octave and hands the running sums, the next
  // frequency and the next amplitude to its neighbor.
  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_cell
    fgn_cell #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_cell (
      .clk             (clk),
      .rst_n           (rst_n),
      .in_vld          (chain_vld[i]),
      .in_item         (chain_item[i]),
      .cfg_persistence (persistence_r),
      .cfg_lacunarity  (lacunarity_r),
      .out_vld         (chain_vld[i+1]),
      .out_item        (chain_item[i+1])
    );
  end

  // Normalize by the weight sum and map [-1,1] onto [0,1].
  fgn_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (chain_vld[MAX_OCTAVES]),
    .in_total  (chain_item[MAX_OCTAVES].total),
    .in_wsum   (chain_item[MAX_OCTAVES].wsum),
    .out_vld   (out_valid),
    .out_value (out_noise_value)
  );

endmodule

FILE: hdl/fgn_cell.sv
// One octave cell of the noise chain: nine pipeline stages per octave.
`timescale 1ns / 1ps
module fgn_cell #(
  parameter int COORD_FRAC_BITS = fgn_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  fgn_pkg::item_t             in_item,
  input  logic [fgn_pkg::CFG_W-1:0]  cfg_persistence,
  input  logic [fgn_pkg::CFG_W-1:0]  cfg_lacunarity,
  output logic                       out_vld,
  output fgn_pkg::item_t             out_item
);

  localparam int PW  = COORD_FRAC_BITS + 24;
  localparam int SPL = PW / 2;
  localparam int HI  = PW - SPL;
  localparam int LAT = 9;

  function automatic logic signed [18:0] grad(input logic [7:0] hash,
                                              input logic signed [17:0] x,
                                              input logic signed [17:0] y);
    logic [3:0] h;
    logic signed [18:0] u;
    logic signed [18:0] v;
    h = hash[3:0];
    u = (h < 4'd8) ? 19'(x) : 19'(y);
    if (h < 4'd4) begin
      v = 19'(y);
    end else if (h inside {4'd12, 4'd14}) begin
      v = 19'(x);
    end else begin
      v = '0;
    end
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic [21:0] fade_poly(input logic [15:0] t, input logic [31:0] tt);
    logic [37:0] acc;
    acc = 38'(tt) * 38'd6 + (38'd10 << 32) - ((38'(t) * 38'd15) << 16);
    return acc[37:16];
  endfunction

  logic           vld_r [1:LAT];
  fgn_pkg::item_t it_r  [1:LAT];
  fgn_pkg::item_t it2_nxt;
  fgn_pkg::item_t it9_nxt;

  // Stage 1: partial products.
  logic [PW-1:0]     cx_e, cy_e;
  logic [PW+SPL-1:0] px0_full, py0_full;
  logic [2*HI-1:0]   px1_full, py1_full;
  logic [PW-1:0]     px0_r, py0_r;
  logic [HI-1:0]     px1_r, py1_r;
  logic [39:0]       fp0_nxt, fp1_nxt, fp0_r, fp1_r;

  // Stage 2: scaled coordinates.
  logic [PW-1:0]     px, py;
  logic [63:0]       fsum;
  logic [51:0]       fsh;
  logic [7:0]        ix_r, iy_r;
  logic [15:0]       fx_r, fy_r;

  // Stage 3.
  logic [31:0]       ttu_r, ttv_r;
  logic [7:0]        a_r, b_r;
  logic [15:0]       fx3_r, fy3_r;

  // Stage 4.
  logic [31:0]       t3u_full, t3v_full;
  logic [15:0]       t3u_r, t3v_r;
  logic [21:0]       qu_r, qv_r;
  logic [7:0]        aa_r, ab_r, ba_r, bb_r;
  logic [15:0]       fx4_r, fy4_r;

  // Stage 5.
  logic [37:0]        fu_full, fv_full;
  logic [15:0]        fu_r, fv_r;
  logic signed [17:0] sx, sy, sx1, sy1;
  logic signed [18:0] g00_r, g10_r, g01_r, g11_r;

  // Stage 6.
  logic signed [20:0] du_lo, du_hi;
  logic signed [37:0] pu_lo, pu_hi;
  logic signed [19:0] lo_r, hi_r;
  logic [15:0]        fv6_r;

  // Stage 7.
  logic signed [20:0] dv;
  logic signed [37:0] pv;
  logic signed [19:0] noise_r;

  // Stage 8.
  logic signed [37:0] wt_nxt, wt_r;
  logic [32:0]        ap_nxt, ap_r;

  always_comb begin
    cx_e     = {{COORD_FRAC_BITS{in_item.cx[23]}}, in_item.cx};
    cy_e     = {{COORD_FRAC_BITS{in_item.cy[23]}}, in_item.cy};
    px0_full = cx_e * in_item.freq[SPL-1:0];
    py0_full = cy_e * in_item.freq[SPL-1:0];
    px1_full = cx_e[HI-1:0] * in_item.freq[PW-1:SPL];
    py1_full = cy_e[HI-1:0] * in_item.freq[PW-1:SPL];
    fp0_nxt  = in_item.freq[23:0] * cfg_lacunarity;
    fp1_nxt  = in_item.freq[47:24] * cfg_lacunarity;

    px   = px0_r + {px1_r, {SPL{1'b0}}};
    py   = py0_r + {py1_r, {SPL{1'b0}}};
    fsum = {24'b0, fp0_r} + {fp1_r, 24'b0};
    fsh  = fsum[63:12];
    it2_nxt = it_r[1];
    it2_nxt.freq = (|fsh[51:48]) ? '1 : fsh[47:0];

    t3u_full = ttu_r[31:16] * fx3_r;
    t3v_full = ttv_r[31:16] * fy3_r;

    fu_full = t3u_r * qu_r;
    fv_full = t3v_r * qv_r;
    sx  = $signed({2'b0, fx4_r});
    sy  = $signed({2'b0, fy4_r});
    sx1 = sx - 18'sd65536;
    sy1 = sy - 18'sd65536;

    du_lo = 21'(g10_r) - 21'(g00_r);
    du_hi = 21'(g11_r) - 21'(g01_r);
    pu_lo = $signed({1'b0, fu_r}) * du_lo;
    pu_hi = $signed({1'b0, fu_r}) * du_hi;

    dv = 21'(hi_r) - 21'(lo_r);
    pv = $signed({1'b0, fv6_r}) * dv;

    wt_nxt = noise_r * $signed({1'b0, it_r[7].amp});
    ap_nxt = it_r[7].amp * cfg_persistence;

    // Octaves past the configured count leave the sums untouched.
    it9_nxt = it_r[8];
    if (it_r[8].left != '0) begin
      it9_nxt.total = $signed(it_r[8].total) + fgn_pkg::TOT_W'(wt_r);
      it9_nxt.wsum  = it_r[8].wsum + fgn_pkg::WSUM_W'(it_r[8].amp);
      it9_nxt.left  = it_r[8].left - 1'b1;
    end
    it9_nxt.amp = ap_r[32:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= LAT; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else begin
      vld_r[1] <= in_vld;
      for (int s = 2; s <= LAT; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    // Stage 1
    it_r[1] <= in_item;
    px0_r   <= px0_full[PW-1:0];
    py0_r   <= py0_full[PW-1:0];
    px1_r   <= px1_full[HI-1:0];
    py1_r   <= py1_full[HI-1:0];
    fp0_r   <= fp0_nxt;
    fp1_r   <= fp1_nxt;
    // Stage 2
    it_r[2] <= it2_nxt;
    ix_r    <= px[PW-1 -: 8];
    iy_r    <= py[PW-1 -: 8];
    fx_r    <= px[COORD_FRAC_BITS +: 16];
    fy_r    <= py[COORD_FRAC_BITS +: 16];
    // Stage 3
    it_r[3] <= it_r[2];
    ttu_r   <= fx_r * fx_r;
    ttv_r   <= fy_r * fy_r;
    a_r     <= fgn_pkg::PERM[ix_r] + iy_r;
    b_r     <= fgn_pkg::PERM[ix_r + 8'd1] + iy_r;
    fx3_r   <= fx_r;
    fy3_r   <= fy_r;
    // Stage 4
    it_r[4] <= it_r[3];
    t3u_r   <= t3u_full[31:16];
    t3v_r   <= t3v_full[31:16];
    qu_r    <= fade_poly(fx3_r, ttu_r);
    qv_r    <= fade_poly(fy3_r, ttv_r);
    aa_r    <= fgn_pkg::PERM[a_r];
    ab_r    <= fgn_pkg::PERM[a_r + 8'd1];
    ba_r    <= fgn_pkg::PERM[b_r];
    bb_r    <= fgn_pkg::PERM[b_r + 8'd1];
    fx4_r   <= fx3_r;
    fy4_r   <= fy3_r;
    // Stage 5
    it_r[5] <= it_r[4];
    fu_r    <= (|fu_full[37:32]) ? 16'hFFFF : fu_full[31:16];
    fv_r    <= (|fv_full[37:32]) ? 16'hFFFF : fv_full[31:16];
    g00_r   <= grad(fgn_pkg::PERM[aa_r], sx, sy);
    g10_r   <= grad(fgn_pkg::PERM[ba_r], sx1, sy);
    g01_r   <= grad(fgn_pkg::PERM[ab_r], sx, sy1);
    g11_r   <= grad(fgn_pkg::PERM[bb_r], sx1, sy1);
    // Stage 6
    it_r[6] <= it_r[5];
    lo_r    <= 20'(g00_r) + 20'(pu_lo >>> 16);
    hi_r    <= 20'(g01_r) + 20'(pu_hi >>> 16);
    fv6_r   <= fv_r;
    // Stage 7
    it_r[7] <= it_r[6];
    noise_r <= lo_r + 20'(pv >>> 16);
    // Stage 8
    it_r[8] <= it_r[7];
    wt_r    <= wt_nxt;
    ap_r    <= ap_nxt;
    // Stage 9
    it_r[9] <= it9_nxt;
  end

  assign out_vld  = vld_r[LAT];
  assign out_item = it_r[LAT];

endmodule

FILE: hdl/fgn_div.sv
// Pipelined normalizing divider: one quotient bit per restoring step, with clamping to zero and saturation.
`timescale 1ns / 1ps
module fgn_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_vld,
  input  logic signed [fgn_pkg::TOT_W-1:0]   in_total,
  input  logic [fgn_pkg::WSUM_W-1:0]         in_wsum,
  output logic                               out_vld,
  output logic [fgn_pkg::OUT_W-1:0]          out_value
);

  localparam int NB   = fgn_pkg::OUT_W;
  localparam int LAST = NB + 1;

  logic [fgn_pkg::NUM_W-1:0]   num_nxt, num_r;
  logic [fgn_pkg::DIV_D_W-1:0] d_r   [0:LAST];
  logic                        vld_r [0:LAST];
  logic [fgn_pkg::REM_W-1:0]   rem_r [1:LAST];
  logic [NB-1:0]               q_r   [1:LAST];
  logic                        zero_r [1:LAST];
  logic                        sat_r  [1:LAST];
  logic                        zero_nxt, sat_nxt;
  logic                        out_vld_r;
  logic [NB-1:0]               out_value_r;

  always_comb begin
    num_nxt  = fgn_pkg::NUM_W'(in_total) + fgn_pkg::NUM_W'({in_wsum, 16'b0});
    zero_nxt = num_r[fgn_pkg::NUM_W-1] || (num_r == '0);
    sat_nxt  = num_r[fgn_pkg::NUM_W-2:0] >= (fgn_pkg::NUM_W-1)'({d_r[0], 16'b0});
  end

  always_ff @(posedge clk) begin
    num_r     <= num_nxt;
    d_r[0]    <= {in_wsum, 1'b0};
    d_r[1]    <= d_r[0];
    rem_r[1]  <= num_r[fgn_pkg::REM_W-1:0];
    q_r[1]    <= '0;
    zero_r[1] <= zero_nxt;
    sat_r[1]  <= sat_nxt;
  end

  // Restoring steps, most significant quotient bit first.
  for (genvar s = 2; s <= LAST; s++) begin : g_step
    localparam int K = LAST - s;
    logic [fgn_pkg::REM_W-1:0] dsh;
    logic                      ge;
    always_comb begin
      dsh = fgn_pkg::REM_W'(d_r[s-1]) << K;
      ge  = rem_r[s-1] >= dsh;
    end
    always_ff @(posedge clk) begin
      d_r[s]    <= d_r[s-1];
      rem_r[s]  <= ge ? (rem_r[s-1] - dsh) : rem_r[s-1];
      q_r[s]    <= q_r[s-1] | (NB'(ge) << K);
      zero_r[s] <= zero_r[s-1];
      sat_r[s]  <= sat_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= LAST; s++) begin
        vld_r[s] <= 1'b0;
      end
      out_vld_r <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int s = 1; s <= LAST; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
      out_vld_r <= vld_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (zero_r[LAST]) begin
      out_value_r <= '0;
    end else if (sat_r[LAST]) begin
      out_value_r <= '1;
    end else begin
      out_value_r <= q_r[LAST];
    end
  end

  assign out_vld   = out_vld_r;
  assign out_value = out_value_r;

endmodule
